// ----- design/pngu_pkg.sv -----
// ----------------------------------------------------------------------------
// pngu_pkg: shared types and constants of the PNG scanline unfilter
// Line store size, column widths, register indexes, filter codes and the
// item format that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package pngu_pkg;

    // Line store size and derived widths
    localparam int MAX_ROW_BYTES = 8192;
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CNT_W = COL_W + 1;
    localparam int LEN_W = 14;
    localparam int BPP_W = 3;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_BYTES = 1'b0,
        CFG_ROW_LENGTH  = 1'b1
    } cfg_idx_t;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [LEN_W-1:0] LEN_RESET = 14'd4;

    // Row filter codes as they arrive on the stream
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // Reconstruction rule chosen by the front part
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SUB   = 3'd1,
        OP_UP    = 3'd2,
        OP_AVG   = 3'd3,
        OP_PAETH = 3'd4,
        OP_BAD   = 3'd5
    } op_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0]       data;
        op_t              op;
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             clear_hist;
        logic             last;
    } item_t;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [Q_PTR_W:0] count;
    } q_stat_t;

endpackage

// ----- design/pngu_in_if.sv -----
// ----------------------------------------------------------------------------
// pngu_in_if: filtered byte channel
// One filtered scanline byte per beat with its row and image marks.
// ----------------------------------------------------------------------------
interface pngu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] filter_code;
    logic       row_begin;
    logic       image_begin;

    modport source (
        output valid, data_byte, filter_code, row_begin, image_begin,
        input  ready
    );
    modport sink (
        input  valid, data_byte, filter_code, row_begin, image_begin,
        output ready
    );
endinterface

// ----- design/pngu_out_if.sv -----
// ----------------------------------------------------------------------------
// pngu_out_if: reconstructed byte channel
// One reconstructed byte per beat with its row end and error marks.
// ----------------------------------------------------------------------------
interface pngu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] recon_byte;
    logic       row_end;
    logic       bad_filter;

    modport source (
        output valid, recon_byte, row_end, bad_filter,
        input  ready
    );
    modport sink (
        input  valid, recon_byte, row_end, bad_filter,
        output ready
    );
endinterface

// ----- design/pngu_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pngu_cfg_if: configuration write channel
// One register write per beat: register index and write data.
// ----------------------------------------------------------------------------
interface pngu_cfg_if;
    import pngu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- design/pngu_ram.sv -----
// ----------------------------------------------------------------------------
// pngu_ram: generic simple dual-port RAM
// One write port and one read port; read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/pngu_front.sv -----
// ----------------------------------------------------------------------------
// pngu_front: byte intake and classification
// Tracks column, row filter and first-row state, picks the reconstruction
// rule and pushes one classified item per accepted beat into the queue.
// ----------------------------------------------------------------------------
module pngu_front (
    input  logic                      clk,
    input  logic                      rst_n,
    pngu_in_if.sink                   filtered,
    input  logic [pngu_pkg::CNT_W-1:0] len_eff,
    input  logic                      q_full,
    output logic                      push,
    output pngu_pkg::item_t           push_item
);
    import pngu_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [7:0]       filt_reg;
    logic [7:0]       filt_next;
    logic             first_reg;
    logic             first_next;

    logic             row_start;
    logic [COL_W-1:0] col_pre;
    logic [COL_W-1:0] col_cur;
    logic [CNT_W-1:0] col_plus;
    logic             last;
    op_t              op;

    // Accept whenever the queue has room
    assign filtered.ready = !q_full;
    assign push           = filtered.valid && filtered.ready;

    // Row bookkeeping for the beat on the port
    always_comb
    begin
        row_start  = filtered.row_begin || filtered.image_begin;
        first_next = filtered.image_begin || first_reg;
        filt_next  = row_start ? filtered.filter_code : filt_reg;
        col_pre    = row_start ? '0 : col_reg;
        col_cur    = ({1'b0, col_pre} >= len_eff) ? '0 : col_pre;
        col_plus   = {1'b0, col_cur} + CNT_W'(1);
        last       = (col_plus >= len_eff);
        col_next   = last ? '0 : col_plus[COL_W-1:0];
    end

    // Decode the row filter
    always_comb
    begin
        unique case (filt_next)
            FILT_NONE:  op = OP_NONE;
            FILT_SUB:   op = OP_SUB;
            FILT_UP:    op = OP_UP;
            FILT_AVG:   op = OP_AVG;
            FILT_PAETH: op = OP_PAETH;
            default:    op = OP_BAD;
        endcase
    end

    // Build the queue item
    always_comb
    begin
        push_item.data       = filtered.data_byte;
        push_item.op         = op;
        push_item.col        = col_cur;
        push_item.first_row  = first_next;
        push_item.clear_hist = row_start;
        push_item.last       = last;
    end

    // Advance row state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            filt_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (push)
        begin
            col_reg   <= col_next;
            filt_reg  <= filt_next;
            first_reg <= last ? 1'b0 : first_next;
        end
    end

endmodule

// ----- design/pngu_queue.sv -----
// ----------------------------------------------------------------------------
// pngu_queue: short item queue between front and back
// Register FIFO of classified items; head is visible while not empty.
// ----------------------------------------------------------------------------
module pngu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pngu_pkg::item_t     push_item,
    input  logic                pop,
    output pngu_pkg::item_t     head_item,
    output logic                head_valid,
    output pngu_pkg::q_stat_t   stat
);
    import pngu_pkg::*;

    item_t              slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    // Status and head
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_valid = !stat.empty;
    assign head_item  = slot[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (Q_PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (Q_PTR_W + 1)'(1);
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/pngu_back.sv -----
// ----------------------------------------------------------------------------
// pngu_back: byte reconstruction
// Reads the line store as an item leaves the queue, rebuilds the byte in the
// execute stage, writes it back and hands it to the output register.
// ----------------------------------------------------------------------------
module pngu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pngu_pkg::item_t   head_item,
    input  logic              head_valid,
    output logic              pop,
    input  logic [1:0]        bpp_sel,
    pngu_out_if.source        recon
);
    import pngu_pkg::*;

    // Paeth predictor on bytes
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

    logic        s2_valid_reg;
    item_t       s2_item_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;
    logic [31:0] left_hist_reg;
    logic [31:0] up_hist_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_bad_reg;

    logic        out_adv;
    logic        s2_adv;
    logic [7:0]  rd_data;
    logic [7:0]  stored;
    logic [7:0]  above;
    logic [31:0] lh;
    logic [31:0] uh;
    logic [7:0]  left;
    logic [7:0]  upleft;
    logic [8:0]  avg_sum;
    logic [7:0]  r;
    logic        bad;

    // Stage flow: output register, execute stage, queue pop
    assign out_adv = !out_valid_reg || recon.ready;
    assign s2_adv  = s2_valid_reg && out_adv;
    assign pop     = head_valid && (!s2_valid_reg || out_adv);

    // Line store: read on pop, write on completion
    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .clk     (clk),
        .wr_en   (s2_adv),
        .wr_addr (s2_item_reg.col),
        .wr_data (r),
        .rd_en   (pop),
        .rd_addr (head_item.col),
        .rd_data (rd_data)
    );

    // Gather neighbor bytes
    always_comb
    begin
        stored  = fwd_reg ? fwd_data_reg : rd_data;
        above   = s2_item_reg.first_row ? 8'd0 : stored;
        lh      = s2_item_reg.clear_hist ? 32'd0 : left_hist_reg;
        uh      = s2_item_reg.clear_hist ? 32'd0 : up_hist_reg;
        left    = lh[{bpp_sel, 3'b000} +: 8];
        upleft  = uh[{bpp_sel, 3'b000} +: 8];
        avg_sum = {1'b0, left} + {1'b0, above};
    end

    // Apply the row filter rule
    always_comb
    begin
        bad = 1'b0;
        case (s2_item_reg.op)
            OP_NONE:  r = s2_item_reg.data;
            OP_SUB:   r = s2_item_reg.data + left;
            OP_UP:    r = s2_item_reg.data + above;
            OP_AVG:   r = s2_item_reg.data + avg_sum[8:1];
            OP_PAETH: r = s2_item_reg.data + paeth(left, above, upleft);
            default:
            begin
                r   = 8'd0;
                bad = 1'b1;
            end
        endcase
    end

    // Load the execute stage from the queue head
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_item_reg  <= head_item;
            fwd_data_reg <= r;
        end
    end

    // Track stage valid and same-column bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s2_valid_reg <= 1'b1;
                fwd_reg      <= s2_adv && (s2_item_reg.col == head_item.col);
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // Shift the left and upper-left histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_hist_reg <= '0;
            up_hist_reg   <= '0;
        end
        else if (s2_adv)
        begin
            left_hist_reg <= s2_item_reg.last ? 32'd0 : {lh[23:0], r};
            up_hist_reg   <= s2_item_reg.last ? 32'd0 : {uh[23:0], above};
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_byte_reg <= r;
            out_end_reg  <= s2_item_reg.last;
            out_bad_reg  <= bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (recon.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign recon.valid      = out_valid_reg;
    assign recon.recon_byte = out_byte_reg;
    assign recon.row_end    = out_end_reg;
    assign recon.bad_filter = out_bad_reg;

endmodule

// ----- design/png_scanline_unfilter_top.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top: PNG scanline unfilter
// Rebuilds filtered scanline bytes with the None, Sub, Up, Average and Paeth
// rules, keeping the previous row in an internal line store.
//
//   channel   dir   beat carries
//   filtered  in    data_byte, filter_code, row_begin, image_begin
//   recon     out   recon_byte, row_end, bad_filter
//   cfg       in    index, data (0 pixel_bytes, 1 row_length)
//
// One byte per clock sustained while the output is not stalled; a taken byte
// passes through the queue, the execute stage and the output register before
// it is offered. The rate is set by the execute stage, whose left neighbor may
// be its own last result, and by the single read port of the line store.
// Reset clears control state only; the line store is not cleared, and the
// first row of an image reads its above bytes as zero.
// A four-entry queue, the execute stage and the output register hold up to
// six bytes, so intake continues while the output stalls; cfg is always ready.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top (
    input  logic       clk,
    input  logic       rst_n,
    pngu_in_if.sink    filtered,
    pngu_out_if.source recon,
    pngu_cfg_if.sink   cfg
);
    import pngu_pkg::*;

    logic [BPP_W-1:0] bpp_reg;
    logic [LEN_W-1:0] len_reg;
    logic [1:0]       bpp_sel;
    logic [CMP_W-1:0] len_wide;
    logic [CNT_W-1:0] len_eff;

    logic             push;
    item_t            push_item;
    logic             pop;
    item_t            head_item;
    logic             head_valid;
    q_stat_t          q_stat;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_RESET;
            len_reg <= LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_PIXEL_BYTES: bpp_reg <= cfg.data[BPP_W-1:0];
                CFG_ROW_LENGTH:  len_reg <= cfg.data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp pixel size to 1..4, as a byte select 0..3
    always_comb
    begin
        case (bpp_reg) inside
            3'd0, 3'd1: bpp_sel = 2'd0;
            3'd2:       bpp_sel = 2'd1;
            3'd3:       bpp_sel = 2'd2;
            default:    bpp_sel = 2'd3;
        endcase
    end

    // Clamp row length to 1..MAX_ROW_BYTES
    always_comb
    begin
        len_wide = CMP_W'(len_reg);
        if (len_wide == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (len_wide > CMP_W'(MAX_ROW_BYTES))
        begin
            len_eff = CNT_W'(MAX_ROW_BYTES);
        end
        else
        begin
            len_eff = len_wide[CNT_W-1:0];
        end
    end

    pngu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .filtered  (filtered),
        .len_eff   (len_eff),
        .q_full    (q_stat.full),
        .push      (push),
        .push_item (push_item)
    );

    pngu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .stat       (q_stat)
    );

    pngu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop),
        .bpp_sel    (bpp_sel),
        .recon      (recon)
    );

    // Queue never holds more than its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= (Q_PTR_W + 1)'(Q_DEPTH))
        else $error("queue count above depth");

    // Back part pops only a present item
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    // A pushed item leaves the queue non-empty next cycle
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty after push");

    // Bad filter bytes are forced to zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (recon.valid && recon.bad_filter) |-> (recon.recon_byte == 8'd0))
        else $error("bad filter byte not zero");

endmodule
